// ===== design/rwcp_pkg.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser package
// Types, phase codes, status codes and tag constants shared by the parser.
// ----------------------------------------------------------------------------
package rwcp_pkg;

    typedef enum logic [3:0] {
        PH_RIFF_ID    = 4'd0,
        PH_RIFF_SIZE  = 4'd1,
        PH_WAVE_ID    = 4'd2,
        PH_CK_ID      = 4'd3,
        PH_SIZE_FMT   = 4'd4,
        PH_SIZE_DATA  = 4'd5,
        PH_SIZE_OTHER = 4'd6,
        PH_FMT        = 4'd7,
        PH_DATA       = 4'd8,
        PH_SKIP       = 4'd9,
        PH_PAD        = 4'd10,
        PH_DONE_OK    = 4'd11,
        PH_DONE_BAD   = 4'd12
    } phase_t;

    localparam logic [1:0] ST_PARSING   = 2'd0;
    localparam logic [1:0] ST_OK        = 2'd1;
    localparam logic [1:0] ST_BAD_HDR   = 2'd2;
    localparam logic [1:0] ST_EARLY_END = 2'd3;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
    localparam logic [15:0] FMT_PCM        = 16'h0001;

    localparam int FMT_KEEP = 16;
    localparam int FMT_AW   = 4;
    localparam logic [4:0] FMT_KEEP_CNT = 5'd16;
    localparam logic [4:0] WORD_LAST_CNT = 5'd3;

    typedef struct packed {
        logic              clear;
        logic              rearm;
        logic              wr_en;
        logic [FMT_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
    } store_ctl_t;

    typedef struct packed {
        logic [15:0] bits_per_sample;
        logic [15:0] block_align;
        logic [31:0] byte_rate;
        logic [31:0] sample_rate;
        logic [15:0] channels;
        logic [15:0] format_tag;
    } fmt_fields_t;

    typedef struct packed {
        logic       result;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       data_last;
        logic [1:0] status;
    } step_out_t;

endpackage

// ===== design/riff_wave_chunk_parser.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser
// Parses a WAV byte stream, passes out data chunk bytes and reports status.
// ----------------------------------------------------------------------------
// The s_ channel carries the file one byte per item; s_tlast marks the final
// byte of a file and rearms the parser for the next file. The m_ channel
// carries at most one item per input byte: a data chunk byte, a verdict
// (success, bad header, early end), or both, always with the format fields
// as captured so far. Bytes that bring neither give no m_ item.
// From s_ acceptance to m_tvalid a byte passes one input register, then one
// parse step into the result register. Throughput is one byte per cycle
// while m_tready keeps up, set by the parse step over the phase and size
// registers. When m_tready is low with a result waiting, the parse step
// holds and s_tready drops once the input register is full.
// Reset (aresetn low at a clock edge) empties both registers, returns the
// parser to the RIFF id phase and zeroes the format store.
// ----------------------------------------------------------------------------
module riff_wave_chunk_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] byte_value
    input  logic         s_tlast,   // file_last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // data_byte, format_tag, channels, sample_rate,
                                    // byte_rate, block_align, bits_per_sample
    output logic [2:0]   m_tuser,   // data_valid, status[1:0]
    output logic         m_tlast    // data_last
);
    import rwcp_pkg::*;

    logic        item_valid;
    logic [7:0]  item_byte;
    logic        item_last;
    logic        step;

    store_ctl_t  store_ctl;
    step_out_t   step_out;
    fmt_fields_t fields;

    logic         out_valid_reg;
    logic [135:0] out_data_reg;
    logic [2:0]   out_user_reg;
    logic         out_last_reg;

    assign step = item_valid && (!out_valid_reg || m_tready);

    rwcp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (step),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_last  (item_last)
    );

    rwcp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (item_byte),
        .in_last   (item_last),
        .store_ctl (store_ctl),
        .step_out  (step_out)
    );

    rwcp_fmt_store u_fmt_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .store_ctl (store_ctl),
        .fields    (fields)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= step && step_out.result;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && step_out.result) begin
            out_data_reg <= {fields.bits_per_sample, fields.block_align,
                             fields.byte_rate, fields.sample_rate,
                             fields.channels, fields.format_tag,
                             step_out.data_byte};
            out_user_reg <= {step_out.status, step_out.data_valid};
            out_last_reg <= step_out.data_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/rwcp_in_stage.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser input register
// Holds one file byte and its last flag until the parser takes it.
// ----------------------------------------------------------------------------
module rwcp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic       s_tlast,
    input  logic       take,
    output logic       item_valid,
    output logic [7:0] item_byte,
    output logic       item_last
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

endmodule

// ===== design/rwcp_parser.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser control
// Walks header tags, chunk ids, sizes and bodies one byte per step.
// ----------------------------------------------------------------------------
module rwcp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output rwcp_pkg::store_ctl_t store_ctl,
    output rwcp_pkg::step_out_t  step_out
);
    import rwcp_pkg::*;

    phase_t      phase_reg,     phase_next;
    logic [4:0]  count_reg,     count_next;
    logic [31:0] word_reg,      word_next;
    logic [31:0] left_reg,      left_next;
    logic        odd_reg,       odd_next;
    logic        seen_fmt_reg,  seen_fmt_next;
    logic        seen_data_reg, seen_data_next;

    logic [31:0] word_shifted;
    logic        in_word;
    logic        word_done;
    logic        body_end;
    logic        chunk_end;
    logic [1:0]  verdict;
    logic        dvalid;
    logic        dlast;

    assign word_shifted = {in_byte, word_reg[31:8]};
    assign in_word      = (phase_reg <= PH_SIZE_OTHER);
    assign word_done    = in_word && (count_reg == WORD_LAST_CNT);
    assign body_end     = (left_reg == 32'd1);

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        word_next      = word_reg;
        left_next      = left_reg;
        odd_next       = odd_reg;
        seen_fmt_next  = seen_fmt_reg;
        seen_data_next = seen_data_reg;
        verdict        = ST_PARSING;
        dvalid         = 1'b0;
        dlast          = 1'b0;
        chunk_end      = 1'b0;
        store_ctl      = '0;
        store_ctl.wr_data = in_byte;
        store_ctl.wr_addr = count_reg[FMT_AW-1:0];

        if (in_word) begin
            word_next  = word_shifted;
            count_next = word_done ? 5'd0 : count_reg + 5'd1;
        end

        unique case (phase_reg)
            PH_RIFF_ID: begin
                if (word_done) begin
                    if (word_shifted == TAG_RIFF) begin
                        phase_next = PH_RIFF_SIZE;
                    end else begin
                        phase_next = PH_DONE_BAD;
                        verdict    = ST_BAD_HDR;
                    end
                end
            end
            PH_RIFF_SIZE: begin
                if (word_done) begin
                    phase_next = PH_WAVE_ID;
                end
            end
            PH_WAVE_ID: begin
                if (word_done) begin
                    if (word_shifted == TAG_WAVE) begin
                        phase_next = PH_CK_ID;
                    end else begin
                        phase_next = PH_DONE_BAD;
                        verdict    = ST_BAD_HDR;
                    end
                end
            end
            PH_CK_ID: begin
                if (word_done) begin
                    if (word_shifted == TAG_FMT) begin
                        phase_next = PH_SIZE_FMT;
                    end else if (word_shifted == TAG_DATA) begin
                        phase_next = PH_SIZE_DATA;
                    end else begin
                        phase_next = PH_SIZE_OTHER;
                    end
                end
            end
            PH_SIZE_FMT: begin
                if (word_done) begin
                    left_next       = word_shifted;
                    odd_next        = word_shifted[0];
                    store_ctl.clear = 1'b1;
                    if (word_shifted == 32'd0) begin
                        seen_fmt_next = 1'b1;
                        chunk_end     = 1'b1;
                    end else begin
                        phase_next = PH_FMT;
                    end
                end
            end
            PH_SIZE_DATA: begin
                if (word_done) begin
                    left_next = word_shifted;
                    odd_next  = word_shifted[0];
                    if (word_shifted == 32'd0) begin
                        seen_data_next = 1'b1;
                        chunk_end      = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_SIZE_OTHER: begin
                if (word_done) begin
                    left_next = word_shifted;
                    odd_next  = word_shifted[0];
                    if (word_shifted == 32'd0) begin
                        chunk_end = 1'b1;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_FMT: begin
                if (count_reg < FMT_KEEP_CNT) begin
                    store_ctl.wr_en = 1'b1;
                    count_next      = count_reg + 5'd1;
                end
                left_next = left_reg - 32'd1;
                if (body_end) begin
                    seen_fmt_next = 1'b1;
                    chunk_end     = 1'b1;
                end
            end
            PH_DATA: begin
                dvalid    = 1'b1;
                left_next = left_reg - 32'd1;
                if (body_end) begin
                    dlast          = 1'b1;
                    seen_data_next = 1'b1;
                    chunk_end      = 1'b1;
                end
            end
            PH_SKIP: begin
                left_next = left_reg - 32'd1;
                if (body_end) begin
                    chunk_end = 1'b1;
                end
            end
            PH_PAD: begin
                phase_next = PH_CK_ID;
                count_next = 5'd0;
            end
            PH_DONE_OK, PH_DONE_BAD: begin
            end
            default: begin
            end
        endcase

        if (chunk_end) begin
            count_next = 5'd0;
            if (seen_fmt_next && seen_data_next) begin
                phase_next = PH_DONE_OK;
                verdict    = ST_OK;
            end else begin
                phase_next = odd_next ? PH_PAD : PH_CK_ID;
            end
        end

        if (in_last && (verdict == ST_PARSING) && (phase_next != PH_DONE_OK)
                && (phase_next != PH_DONE_BAD)) begin
            verdict = ST_EARLY_END;
        end

        store_ctl.rearm = in_last;

        step_out.result     = dvalid || (verdict != ST_PARSING);
        step_out.data_byte  = dvalid ? in_byte : 8'd0;
        step_out.data_valid = dvalid;
        step_out.data_last  = dlast;
        step_out.status     = verdict;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_RIFF_ID;
            count_reg     <= '0;
            word_reg      <= '0;
            left_reg      <= '0;
            odd_reg       <= 1'b0;
            seen_fmt_reg  <= 1'b0;
            seen_data_reg <= 1'b0;
        end else if (step) begin
            if (in_last) begin
                phase_reg     <= PH_RIFF_ID;
                count_reg     <= '0;
                word_reg      <= '0;
                left_reg      <= '0;
                odd_reg       <= 1'b0;
                seen_fmt_reg  <= 1'b0;
                seen_data_reg <= 1'b0;
            end else begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                word_reg      <= word_next;
                left_reg      <= left_next;
                odd_reg       <= odd_next;
                seen_fmt_reg  <= seen_fmt_next;
                seen_data_reg <= seen_data_next;
            end
        end
    end

endmodule

// ===== design/rwcp_fmt_store.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser format store
// Captures the leading bytes of the fmt body and decodes the format fields.
// ----------------------------------------------------------------------------
module rwcp_fmt_store (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  rwcp_pkg::store_ctl_t  store_ctl,
    output rwcp_pkg::fmt_fields_t fields
);
    import rwcp_pkg::*;

    logic [7:0] mem_reg  [FMT_KEEP];
    logic [7:0] mem_next [FMT_KEEP];
    logic [15:0] tag_raw;

    always_comb begin
        for (int i = 0; i < FMT_KEEP; i++) begin
            if (store_ctl.clear) begin
                mem_next[i] = 8'd0;
            end else if (store_ctl.wr_en && (store_ctl.wr_addr == FMT_AW'(i))) begin
                mem_next[i] = store_ctl.wr_data;
            end else begin
                mem_next[i] = mem_reg[i];
            end
        end
    end

    assign tag_raw = {mem_next[1], mem_next[0]};

    always_comb begin
        fields.format_tag      = (tag_raw == FMT_EXTENSIBLE) ? FMT_PCM : tag_raw;
        fields.channels        = {mem_next[3], mem_next[2]};
        fields.sample_rate     = {mem_next[7], mem_next[6], mem_next[5], mem_next[4]};
        fields.byte_rate       = {mem_next[11], mem_next[10], mem_next[9], mem_next[8]};
        fields.block_align     = {mem_next[13], mem_next[12]};
        fields.bits_per_sample = {mem_next[15], mem_next[14]};
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < FMT_KEEP; i++) begin
            if (!aresetn) begin
                mem_reg[i] <= 8'd0;
            end else if (step) begin
                mem_reg[i] <= store_ctl.rearm ? 8'd0 : mem_next[i];
            end
        end
    end

endmodule

// ===== design/rwcp_checker.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser port checker
// Watches the result channel of the parser over time.
// ----------------------------------------------------------------------------
module rwcp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);
    import rwcp_pkg::*;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result item changed");

    a_last_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("data_last without data_valid");

    a_item_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[2:1] != ST_PARSING)
        else $error("result item with neither data nor verdict");

    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("data_byte nonzero without data_valid");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item present after reset");

endmodule

bind riff_wave_chunk_parser rwcp_checker u_rwcp_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser testbench
// Feeds whole WAV files one byte per item into the parser, some of them good,
// some cut short, some with broken tags, and some plain noise. Each accepted
// byte is run through a local model of the parse, and every m_ item is checked
// field by field against the oldest expected result. The s_ side pauses and
// the m_ side stalls in random bursts until the tail of the run.
// ----------------------------------------------------------------------------
module tb;
    import rwcp_pkg::*;

    localparam int ITEM_GOAL   = 950;
    localparam int TAIL_START  = 850;
    localparam int CYCLE_LIMIT = 400000;
    localparam int FMT_CAPTURE = 18;
    localparam int MAX_SHOWN   = 10;

    typedef enum logic [1:0] {CK_OTHER, CK_FMT, CK_DATA} chunk_kind_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        data_last;
        logic [1:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
    } wav_result_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       typed;
        logic       silent;
        logic [1:0] status;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [24] = '{
        '{8'h00, 1'b1, 1'b1, 1'b0, ST_EARLY_END},
        '{"R",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"I",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"F",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b1, 1'b0, ST_BAD_HDR},
        '{8'h00, 1'b1, 1'b1, 1'b1, ST_PARSING},
        '{"R",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"I",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"F",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"F",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"W",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"A",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"V",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h00, 1'b0, 1'b1, 1'b0, ST_BAD_HDR},
        '{8'hAA, 1'b0, 1'b1, 1'b1, ST_PARSING},
        '{8'h55, 1'b1, 1'b1, 1'b1, ST_PARSING},
        '{"R",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"I",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"F",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"F",   1'b1, 1'b1, 1'b0, ST_EARLY_END}
    };

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    riff_wave_chunk_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    wav_result_t expected_results [$];
    logic [7:0]  file_bytes [$];
    int          errors = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    int          results_checked = 0;
    int          data_bytes_seen = 0;
    int          verdicts_seen [4] = '{0, 0, 0, 0};
    bit          quiet = 1'b0;
    bit          in_reset = 1'b1;

    phase_t      parse_phase;
    logic [4:0]  byte_index;
    logic [31:0] word_acc;
    logic [31:0] body_left;
    logic        size_odd;
    logic        fmt_done;
    logic        data_done;
    logic [7:0]  fmt_store [FMT_CAPTURE];

    function automatic void clear_parser();
        parse_phase = PH_RIFF_ID;
        byte_index  = '0;
        word_acc    = '0;
        body_left   = '0;
        size_odd    = 1'b0;
        fmt_done    = 1'b0;
        data_done   = 1'b0;
        foreach (fmt_store[i]) fmt_store[i] = '0;
    endfunction

    function automatic logic [1:0] close_chunk();
        byte_index = '0;
        if (fmt_done && data_done) begin
            parse_phase = PH_DONE_OK;
            return ST_OK;
        end
        parse_phase = size_odd ? PH_PAD : PH_CK_ID;
        return ST_PARSING;
    endfunction

    // Advance the parse by one byte; return 1 when the byte yields an m_ item.
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output wav_result_t res);
        logic [1:0]  verdict;
        logic        dvalid;
        logic        dlast;
        logic        word_done;
        logic [15:0] ftag;
        verdict   = ST_PARSING;
        dvalid    = 1'b0;
        dlast     = 1'b0;
        word_done = 1'b0;
        res       = '0;
        if (parse_phase <= PH_SIZE_OTHER) begin
            word_acc   = {b, word_acc[31:8]};
            byte_index = byte_index + 5'd1;
            if (byte_index >= 5'd4) begin
                byte_index = '0;
                word_done  = 1'b1;
            end
        end
        case (parse_phase)
            PH_RIFF_ID: if (word_done) begin
                if (word_acc == TAG_RIFF) begin
                    parse_phase = PH_RIFF_SIZE;
                end else begin
                    parse_phase = PH_DONE_BAD;
                    verdict     = ST_BAD_HDR;
                end
            end
            PH_RIFF_SIZE: if (word_done) parse_phase = PH_WAVE_ID;
            PH_WAVE_ID: if (word_done) begin
                if (word_acc == TAG_WAVE) begin
                    parse_phase = PH_CK_ID;
                end else begin
                    parse_phase = PH_DONE_BAD;
                    verdict     = ST_BAD_HDR;
                end
            end
            PH_CK_ID: if (word_done) begin
                if (word_acc == TAG_FMT) parse_phase = PH_SIZE_FMT;
                else if (word_acc == TAG_DATA) parse_phase = PH_SIZE_DATA;
                else parse_phase = PH_SIZE_OTHER;
            end
            PH_SIZE_FMT, PH_SIZE_DATA, PH_SIZE_OTHER: if (word_done) begin
                body_left = word_acc;
                size_odd  = word_acc[0];
                if (parse_phase == PH_SIZE_FMT) begin
                    foreach (fmt_store[i]) fmt_store[i] = '0;
                    if (body_left == 0) begin
                        fmt_done = 1'b1;
                        verdict  = close_chunk();
                    end else begin
                        parse_phase = PH_FMT;
                    end
                end else if (parse_phase == PH_SIZE_DATA) begin
                    if (body_left == 0) begin
                        data_done = 1'b1;
                        verdict   = close_chunk();
                    end else begin
                        parse_phase = PH_DATA;
                    end
                end else begin
                    if (body_left == 0) verdict = close_chunk();
                    else parse_phase = PH_SKIP;
                end
            end
            PH_FMT: begin
                if (byte_index < FMT_CAPTURE) begin
                    fmt_store[byte_index] = b;
                    byte_index = byte_index + 5'd1;
                end
                body_left = body_left - 1;
                if (body_left == 0) begin
                    fmt_done = 1'b1;
                    verdict  = close_chunk();
                end
            end
            PH_DATA: begin
                dvalid    = 1'b1;
                body_left = body_left - 1;
                if (body_left == 0) begin
                    dlast     = 1'b1;
                    data_done = 1'b1;
                    verdict   = close_chunk();
                end
            end
            PH_SKIP: begin
                body_left = body_left - 1;
                if (body_left == 0) verdict = close_chunk();
            end
            PH_PAD: begin
                parse_phase = PH_CK_ID;
                byte_index  = '0;
            end
            default: ;
        endcase
        if (last && verdict == ST_PARSING && parse_phase != PH_DONE_OK
                && parse_phase < PH_DONE_BAD)
            verdict = ST_EARLY_END;
        ftag = {fmt_store[1], fmt_store[0]};
        if (ftag == FMT_EXTENSIBLE) ftag = FMT_PCM;
        res.data_byte       = dvalid ? b : 8'h00;
        res.data_valid      = dvalid;
        res.data_last       = dlast;
        res.status          = verdict;
        res.format_tag      = ftag;
        res.channels        = {fmt_store[3], fmt_store[2]};
        res.sample_rate     = {fmt_store[7], fmt_store[6], fmt_store[5], fmt_store[4]};
        res.byte_rate       = {fmt_store[11], fmt_store[10], fmt_store[9], fmt_store[8]};
        res.block_align     = {fmt_store[13], fmt_store[12]};
        res.bits_per_sample = {fmt_store[15], fmt_store[14]};
        if (last) clear_parser();
        return dvalid || verdict != ST_PARSING;
    endfunction

    function automatic void log_fault(input string msg);
        errors++;
        if (errors <= MAX_SHOWN) $display("%s", msg);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        file_bytes = {file_bytes, b};
    endfunction

    function automatic void add_expected(input wav_result_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) add_byte(w[8*k +: 8]);
    endfunction

    function automatic void put_chunk(input chunk_kind_t kind, input bit with_pad);
        logic [31:0] size;
        logic [15:0] ftag;
        logic [31:0] id;
        case (kind)
            CK_FMT: begin
                id = TAG_FMT;
                case ($urandom_range(0, 3))
                    0: size = 0;
                    1: size = $urandom_range(1, 17);
                    2: size = 18;
                    default: size = $urandom_range(19, 24);
                endcase
            end
            CK_DATA: begin
                id   = TAG_DATA;
                size = $urandom_range(0, 9);
            end
            default: begin
                id   = $urandom;
                size = $urandom_range(0, 6);
            end
        endcase
        case ($urandom_range(0, 3))
            0: ftag = FMT_PCM;
            1: ftag = FMT_EXTENSIBLE;
            2: ftag = 16'hFFFF;
            default: ftag = 16'($urandom);
        endcase
        put_word(id);
        put_word(size);
        for (int k = 0; k < size; k++) begin
            if (kind == CK_FMT && k < 2) add_byte(ftag[8*k +: 8]);
            else add_byte(any_byte());
        end
        if (size[0] && with_pad) add_byte(any_byte());
    endfunction

    // Build one file: mostly well-formed with random chunk order and content,
    // the rest noise, broken tags, truncated files and runaway data sizes.
    function automatic void build_file();
        int          kind;
        int          cut;
        int          j;
        chunk_kind_t swap;
        chunk_kind_t plan [$];
        file_bytes.delete();
        kind = $urandom_range(0, 11);
        if (kind == 0) begin
            repeat ($urandom_range(1, 16)) add_byte(any_byte());
            return;
        end
        put_word(kind == 1 ? TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)) : TAG_RIFF);
        put_word($urandom);
        put_word(kind == 2 ? TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)) : TAG_WAVE);
        if (kind == 4) begin
            put_chunk(CK_FMT, 1'b1);
            put_word(TAG_DATA);
            put_word(32'hFFFF_0000 | 32'($urandom_range(0, 16'hFFFF)));
            repeat ($urandom_range(1, 8)) add_byte(any_byte());
            return;
        end
        plan = {plan, CK_FMT};
        plan = {plan, CK_DATA};
        repeat ($urandom_range(0, 2)) plan = {plan, CK_OTHER};
        if (kind == 6) plan = {plan, CK_FMT};
        if (kind == 7) plan = {plan, CK_DATA};
        for (int i = plan.size() - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            swap    = plan[i];
            plan[i] = plan[j];
            plan[j] = swap;
        end
        foreach (plan[i]) put_chunk(plan[i], !(kind == 5 && i == plan.size() - 1));
        if (kind == 3) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end else if (kind != 5) begin
            repeat ($urandom_range(0, 4)) add_byte(any_byte());
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    initial begin
        wav_result_t res;
        wav_result_t typed_res;
        bit          has_res;
        clear_parser();
        repeat (10) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);
        in_reset = 1'b0;
        foreach (DIRECTED_ROWS[i]) begin
            send_byte(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last);
            has_res = parse_byte(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last, res);
            if (DIRECTED_ROWS[i].typed) begin
                typed_res        = '0;
                typed_res.status = DIRECTED_ROWS[i].status;
                if (!DIRECTED_ROWS[i].silent) add_expected(typed_res);
            end else if (has_res) begin
                add_expected(res);
            end
        end
        while (bytes_sent < ITEM_GOAL) begin
            build_file();
            quiet = bytes_sent >= TAIL_START || $urandom_range(0, 3) == 0;
            foreach (file_bytes[i]) begin
                send_byte(file_bytes[i], i == file_bytes.size() - 1);
                if (parse_byte(file_bytes[i], i == file_bytes.size() - 1, res))
                    add_expected(res);
            end
            files_sent++;
        end
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d bytes (%0d random files); checked %0d results, %0d data bytes.",
                 bytes_sent, files_sent, results_checked, data_bytes_seen);
        $display("Verdicts seen: %0d success, %0d bad header, %0d early end; %0d mismatches.",
                 verdicts_seen[ST_OK], verdicts_seen[ST_BAD_HDR],
                 verdicts_seen[ST_EARLY_END], errors);
        if (errors == 0) begin
            $display("** riff_wave_chunk_parser: PASSED **");
        end else begin
            $display("** riff_wave_chunk_parser: FAILED **");
        end
        $finish;
    end

    initial begin
        @(posedge aclk);
        forever begin
            if (quiet || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        wav_result_t got;
        wav_result_t want;
        string       bad;
        if (!in_reset && m_tvalid && m_tready) begin
            got.data_byte       = m_tdata[7:0];
            got.format_tag      = m_tdata[23:8];
            got.channels        = m_tdata[39:24];
            got.sample_rate     = m_tdata[71:40];
            got.byte_rate       = m_tdata[103:72];
            got.block_align     = m_tdata[119:104];
            got.bits_per_sample = m_tdata[135:120];
            got.data_valid      = m_tuser[0];
            got.status          = m_tuser[2:1];
            got.data_last       = m_tlast;
            if (got.data_valid === 1'b1) data_bytes_seen++;
            if (!$isunknown(got.status)) verdicts_seen[got.status]++;
            if (expected_results.size() == 0) begin
                log_fault($sformatf("unexpected result at cycle %0d: %h", cycles, got));
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                bad  = "";
                if (got.data_byte !== want.data_byte) bad = {bad, " data_byte"};
                if (got.data_valid !== want.data_valid) bad = {bad, " data_valid"};
                if (got.data_last !== want.data_last) bad = {bad, " data_last"};
                if (got.status !== want.status) bad = {bad, " status"};
                if (got.format_tag !== want.format_tag) bad = {bad, " format_tag"};
                if (got.channels !== want.channels) bad = {bad, " channels"};
                if (got.sample_rate !== want.sample_rate) bad = {bad, " sample_rate"};
                if (got.byte_rate !== want.byte_rate) bad = {bad, " byte_rate"};
                if (got.block_align !== want.block_align) bad = {bad, " block_align"};
                if (got.bits_per_sample !== want.bits_per_sample)
                    bad = {bad, " bits_per_sample"};
                if (bad != "")
                    log_fault($sformatf("result %0d wrong in%s: expected %h got %h",
                                        results_checked, bad, want, got));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected.",
                     cycles, expected_results.size());
            $display("** riff_wave_chunk_parser: FAILED **");
            $finish;
        end
    end

endmodule
